/* design/ewa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ewa_pkg: shared types and constants for the elevation window average block
// Configuration layout, operation codes, controller states, divider status.
// ----------------------------------------------------------------------------
package ewa_pkg;

   // default geometry, handed to the top level parameters
   localparam int MAP_COLS_MAX_DEF  = 256;
   localparam int MAP_ROWS_MAX_DEF  = 256;
   localparam int WINDOW_RADIUS_DEF = 5;

   // map byte that stands for height_high_mm
   localparam int FULL_SCALE = 254;

   // port widths
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // cols (9 bits) times position (up to 18 bits signed)
   localparam int PRD_W     = 28;
   // magnitude of that product always fits in 26 bits
   localparam int POS_NUM_W = 26;
   // signed map coordinate with room for +/- radius
   localparam int CRD_W     = 28;

   // configuration reset values
   localparam logic [15:0]        FIELD_WIDTH_RST  = 16'd28000;
   localparam logic [15:0]        FIELD_HEIGHT_RST = 16'd15000;
   localparam logic signed [15:0] HEIGHT_LOW_RST   = 16'sd0;
   localparam logic signed [15:0] HEIGHT_HIGH_RST  = 16'sd1000;
   localparam logic [7:0]         MISSING_RST      = 8'd255;
   localparam logic [8:0]         MAP_USED_RST     = 9'd0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FIELD_WIDTH  = 3'd0,
      REG_FIELD_HEIGHT = 3'd1,
      REG_HEIGHT_LOW   = 3'd2,
      REG_HEIGHT_HIGH  = 3'd3,
      REG_MISSING      = 3'd4,
      REG_MAP_WIDTH    = 3'd5,
      REG_MAP_HEIGHT   = 3'd6
   } ewa_reg_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } ewa_op_type;

   typedef struct packed {
      logic [15:0]        field_width_mm;
      logic [15:0]        field_height_mm;
      logic signed [15:0] height_low_mm;
      logic signed [15:0] height_high_mm;
      logic [7:0]         missing_code;
      logic [8:0]         map_width_used;
      logic [8:0]         map_height_used;
   } ewa_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ewa_div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIVX_GO,
      ST_DIVX_WAIT,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_CLIP,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL,
      ST_DIVA_GO,
      ST_DIVA_WAIT,
      ST_SAT,
      ST_OUT
   } ewa_state_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

/* design/ewa_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ewa_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ewa_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/ewa_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ewa_div: iterative unsigned restoring divider
// One quotient bit per cycle; done pulses once per division.
// ----------------------------------------------------------------------------
module ewa_div
   import ewa_pkg::*;
#(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0]      quo,
   output ewa_div_status_type    status
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_sub;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo         = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

/* design/ewa_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ewa_csr: configuration registers
// Plain write port, no read-back; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ewa_csr
   import ewa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output ewa_cfg_type                cfg
);

   ewa_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (ewa_reg_type'(csr_addr))
            REG_FIELD_WIDTH:  cfg_in.field_width_mm  = csr_wdata;
            REG_FIELD_HEIGHT: cfg_in.field_height_mm = csr_wdata;
            REG_HEIGHT_LOW:   cfg_in.height_low_mm   = signed'(csr_wdata);
            REG_HEIGHT_HIGH:  cfg_in.height_high_mm  = signed'(csr_wdata);
            REG_MISSING:      cfg_in.missing_code    = csr_wdata[7:0];
            REG_MAP_WIDTH:    cfg_in.map_width_used  = csr_wdata[8:0];
            REG_MAP_HEIGHT:   cfg_in.map_height_used = csr_wdata[8:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_width_mm  <= FIELD_WIDTH_RST;
         cfg_ff.field_height_mm <= FIELD_HEIGHT_RST;
         cfg_ff.height_low_mm   <= HEIGHT_LOW_RST;
         cfg_ff.height_high_mm  <= HEIGHT_HIGH_RST;
         cfg_ff.missing_code    <= MISSING_RST;
         cfg_ff.map_width_used  <= MAP_USED_RST;
         cfg_ff.map_height_used <= MAP_USED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* design/elevation_window_average_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elevation_window_average_top: windowed mean height lookup over a byte map
//
// req channel: tuser selects the operation. A write stores one map byte and
// gives no response; a query converts a field position in mm to a map cell,
// averages the non-missing bytes of the surrounding square window (clipped
// to the map in use) and returns one rsp transaction with the height in mm
// and the number of cells that held data.
// Writes are taken one per cycle while the controller is idle. A query is
// worked on alone; it runs up to three divisions on the shared iterative
// divider (31 bits wide at default parameters, one quotient bit per cycle)
// and reads up to 121 window cells from the map RAM, one per cycle.
// The response sits in an output register: a stalled rsp side only holds the
// controller in its final state; writes and queries are taken again as soon
// as the result has moved into that register.
// Reset (synchronous) returns the controller to idle, drops any pending
// response and restores the configuration defaults. The map RAM is not
// cleared; cells must be written before any query window covers them.
// csr writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module elevation_window_average_top
   import ewa_pkg::*;
#(
   parameter int MAP_COLS_MAX  = MAP_COLS_MAX_DEF,
   parameter int MAP_ROWS_MAX  = MAP_ROWS_MAX_DEF,
   parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tuser = operation
   // tdata = cell_column[7:0], cell_row[15:8], cell_value[23:16],
   //         pos_x_mm[40:24], pos_y_mm[57:41], zero pad[63:58]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   // response: tdata = height_mm[15:0], valid_cells[22:16], zero pad[23]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN_SIDE  = 2 * WINDOW_RADIUS + 1;
   localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
   localparam int CNT_W     = $clog2(WIN_CELLS + 1);
   localparam int SUM_W     = $clog2(WIN_CELLS * 255 + 1);
   localparam int COL_W     = $clog2(MAP_COLS_MAX);
   localparam int ROW_W     = $clog2(MAP_ROWS_MAX);
   localparam int MAP_DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);
   localparam int AVG_NUM_W = SUM_W + 16;
   localparam int DIV_NUM_W = max_int(POS_NUM_W, AVG_NUM_W);
   localparam int DEN_W     = max_int(16, CNT_W + 8);
   localparam int PA_W      = SUM_W + 18;
   localparam int HW        = AVG_NUM_W + 2;

   localparam logic signed [HW-1:0]    H_MAX  = HW'(32767);
   localparam logic signed [HW-1:0]    H_MIN  = HW'(-32768);
   localparam logic signed [CRD_W-1:0] RADIUS = CRD_W'(WINDOW_RADIUS);

   // ---------------------------------------------------------------- config
   ewa_cfg_type cfg;

   ewa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // --------------------------------------------------------------- request
   logic              req_accept;
   ewa_op_type        req_op;
   logic [7:0]        req_col;
   logic [7:0]        req_row;
   logic [7:0]        req_val;

   assign req_accept = req_tvalid && req_tready;
   assign req_op     = ewa_op_type'(req_tuser);
   assign req_col    = req_tdata[7:0];
   assign req_row    = req_tdata[15:8];
   assign req_val    = req_tdata[23:16];

   // ------------------------------------------------------------- registers
   ewa_state_type              state_ff, state_in;
   logic signed [16:0]         px_ff, px_in;
   logic signed [16:0]         py_ff, py_in;
   logic signed [PRD_W-1:0]    prod_x_ff, prod_x_in;
   logic signed [PRD_W-1:0]    prod_y_ff, prod_y_in;
   logic                       neg_ff, neg_in;
   logic signed [CRD_W-1:0]    cx_ff, cx_in;
   logic signed [CRD_W-1:0]    cy_ff, cy_in;
   logic [COL_W-1:0]           xs_ff, xs_in, xe_ff, xe_in, col_ff, col_in;
   logic [ROW_W-1:0]           ys_ff, ys_in, ye_ff, ye_in, row_ff, row_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [PA_W-1:0]     prod_a_ff, prod_a_in;
   logic [DEN_W-1:0]           den_a_ff, den_a_in;
   logic [DIV_NUM_W-1:0]       q_ff, q_in;
   logic [15:0]                res_h_ff, res_h_in;
   logic [6:0]                 res_n_ff, res_n_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   // ---------------------------------------------------------- divider, RAM
   logic                       div_start;
   logic [DIV_NUM_W-1:0]       div_num;
   logic [DEN_W-1:0]           div_den;
   logic [DIV_NUM_W-1:0]       div_quo;
   ewa_div_status_type         div_st;

   ewa_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quo    (div_quo),
      .status (div_st)
   );

   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [7:0]                 ram_rd_data;

   assign ram_wr_en   = req_accept && (req_op == OP_WRITE) &&
                        (32'(req_col) < MAP_COLS_MAX) && (32'(req_row) < MAP_ROWS_MAX);
   assign ram_wr_addr = ADDR_W'(32'(req_row) * MAP_COLS_MAX + 32'(req_col));
   assign ram_rd_addr = ADDR_W'(32'(row_ff) * MAP_COLS_MAX + 32'(col_ff));

   ewa_ram #(
      .WIDTH (8),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_val),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------ shared datapath
   logic [8:0]                 cols;
   logic [8:0]                 rows;
   logic [15:0]                fw;
   logic [15:0]                fh;
   logic                       map_empty;
   logic signed [17:0]         py_sum;
   logic signed [16:0]         h_diff;
   logic signed [PRD_W-1:0]    abs_x;
   logic signed [PRD_W-1:0]    abs_y;
   logic signed [PA_W-1:0]     abs_a;
   logic signed [CRD_W-1:0]    q_pos;
   logic signed [CRD_W-1:0]    lim_x, lim_y;
   logic signed [CRD_W-1:0]    xs_w, xe_w, ys_w, ye_w;
   logic signed [CRD_W-1:0]    xs_c, xe_c, ys_c, ye_c;
   logic                       clip_empty;
   logic                       scan_last;
   logic signed [HW-1:0]       h_q;
   logic signed [HW-1:0]       h_sum;
   logic                       out_load;

   always_comb begin
      cols = (32'(cfg.map_width_used) > MAP_COLS_MAX) ? 9'(MAP_COLS_MAX)
                                                       : cfg.map_width_used;
      rows = (32'(cfg.map_height_used) > MAP_ROWS_MAX) ? 9'(MAP_ROWS_MAX)
                                                        : cfg.map_height_used;
      fw   = (cfg.field_width_mm == 16'd0) ? 16'd1 : cfg.field_width_mm;
      fh   = (cfg.field_height_mm == 16'd0) ? 16'd1 : cfg.field_height_mm;
      map_empty = (cols == 9'd0) || (rows == 9'd0);

      py_sum = 18'(py_ff) + 18'(fh);
      h_diff = 17'(cfg.height_high_mm) - 17'(cfg.height_low_mm);

      abs_x = prod_x_ff[PRD_W-1] ? -prod_x_ff : prod_x_ff;
      abs_y = prod_y_ff[PRD_W-1] ? -prod_y_ff : prod_y_ff;
      abs_a = prod_a_ff[PA_W-1]  ? -prod_a_ff : prod_a_ff;

      q_pos = CRD_W'(div_quo[POS_NUM_W-1:0]);

      // window clipped to the map in use
      lim_x = signed'(CRD_W'(cols)) - CRD_W'(1);
      lim_y = signed'(CRD_W'(rows)) - CRD_W'(1);
      xs_w  = cx_ff - RADIUS;
      xe_w  = cx_ff + RADIUS;
      ys_w  = cy_ff - RADIUS;
      ye_w  = cy_ff + RADIUS;
      xs_c  = (xs_w < 0) ? '0 : xs_w;
      ys_c  = (ys_w < 0) ? '0 : ys_w;
      xe_c  = (xe_w > lim_x) ? lim_x : xe_w;
      ye_c  = (ye_w > lim_y) ? lim_y : ye_w;
      clip_empty = (xs_c > xe_c) || (ys_c > ye_c);

      scan_last = (col_ff == xe_ff) && (row_ff == ye_ff);

      h_q   = neg_ff ? -HW'(q_ff[AVG_NUM_W-1:0]) : HW'(q_ff[AVG_NUM_W-1:0]);
      h_sum = h_q + HW'(cfg.height_low_mm);

      out_load = !rsp_tvalid_ff || rsp_tready;
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_op == OP_QUERY)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:     state_in = map_empty ? ST_OUT : ST_DIVX_GO;
         ST_DIVX_GO:   state_in = ST_DIVX_WAIT;
         ST_DIVX_WAIT: state_in = div_st.done ? ST_DIVY_GO : ST_DIVX_WAIT;
         ST_DIVY_GO:   state_in = ST_DIVY_WAIT;
         ST_DIVY_WAIT: state_in = div_st.done ? ST_CLIP : ST_DIVY_WAIT;
         ST_CLIP:      state_in = clip_empty ? ST_OUT : ST_SCAN;
         ST_SCAN:      state_in = scan_last ? ST_DRAIN : ST_SCAN;
         ST_DRAIN:     state_in = ST_MUL;
         ST_MUL:       state_in = (cnt_ff == '0) ? ST_OUT : ST_DIVA_GO;
         ST_DIVA_GO:   state_in = ST_DIVA_WAIT;
         ST_DIVA_WAIT: state_in = div_st.done ? ST_SAT : ST_DIVA_WAIT;
         ST_SAT:       state_in = ST_OUT;
         ST_OUT:       state_in = out_load ? ST_IDLE : ST_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = DEN_W'(1);
      ram_rd_en  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DIVX_GO: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(abs_x[POS_NUM_W-1:0]);
            div_den   = DEN_W'(fw);
         end
         ST_DIVY_GO: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(abs_y[POS_NUM_W-1:0]);
            div_den   = DEN_W'(fh);
         end
         ST_DIVA_GO: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(abs_a[AVG_NUM_W-1:0]);
            div_den   = den_a_ff;
         end
         ST_SCAN: ram_rd_en = 1'b1;
         default: ;
      endcase
   end

   // ------------------------------------------------------------- datapath
   always_comb begin
      px_in         = px_ff;
      py_in         = py_ff;
      prod_x_in     = prod_x_ff;
      prod_y_in     = prod_y_ff;
      neg_in        = neg_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      xs_in         = xs_ff;
      xe_in         = xe_ff;
      ys_in         = ys_ff;
      ye_in         = ye_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      prod_a_in     = prod_a_ff;
      den_a_in      = den_a_ff;
      q_in          = q_ff;
      res_h_in      = res_h_ff;
      res_n_in      = res_n_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_pend_in    = (state_ff == ST_SCAN);

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            px_in = signed'(req_tdata[40:24]);
            py_in = signed'(req_tdata[57:41]);
         end
         ST_SCALE: begin
            prod_x_in = signed'({1'b0, cols}) * px_ff;
            prod_y_in = signed'({1'b0, rows}) * py_sum;
            res_h_in  = '0;
            res_n_in  = '0;
         end
         ST_DIVX_GO: neg_in = prod_x_ff[PRD_W-1];
         ST_DIVX_WAIT: begin
            if (div_st.done) begin
               cx_in = neg_ff ? -q_pos : q_pos;
            end
         end
         ST_DIVY_GO: neg_in = prod_y_ff[PRD_W-1];
         ST_DIVY_WAIT: begin
            if (div_st.done) begin
               cy_in = neg_ff ? -q_pos : q_pos;
            end
         end
         ST_CLIP: begin
            xs_in    = COL_W'(xs_c);
            xe_in    = COL_W'(xe_c);
            ys_in    = ROW_W'(ys_c);
            ye_in    = ROW_W'(ye_c);
            col_in   = COL_W'(xs_c);
            row_in   = ROW_W'(ys_c);
            sum_in   = '0;
            cnt_in   = '0;
            res_h_in = '0;
            res_n_in = '0;
         end
         ST_SCAN: begin
            if (col_ff == xe_ff) begin
               col_in = xs_ff;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_MUL: begin
            prod_a_in = signed'({1'b0, sum_ff}) * h_diff;
            den_a_in  = DEN_W'(cnt_ff) * DEN_W'(FULL_SCALE);
            res_h_in  = '0;
            res_n_in  = '0;
         end
         ST_DIVA_GO: neg_in = prod_a_ff[PA_W-1];
         ST_DIVA_WAIT: begin
            if (div_st.done) begin
               q_in = div_quo;
            end
         end
         ST_SAT: begin
            if (h_sum > H_MAX) begin
               res_h_in = 16'h7FFF;
            end else if (h_sum < H_MIN) begin
               res_h_in = 16'h8000;
            end else begin
               res_h_in = h_sum[15:0];
            end
            res_n_in = (32'(cnt_ff) > 127) ? 7'd127 : 7'(cnt_ff);
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, res_n_ff, res_h_ff};
            end
         end
         default: ;
      endcase

      // read data arrives in the cycle after the address
      if (rd_pend_ff && (ram_rd_data != cfg.missing_code)) begin
         sum_in = sum_ff + SUM_W'(ram_rd_data);
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rd_pend_ff    <= rd_pend_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
      end
      px_ff        <= px_in;
      py_ff        <= py_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      neg_ff       <= neg_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      xs_ff        <= xs_in;
      xe_ff        <= xe_in;
      ys_ff        <= ys_in;
      ye_ff        <= ye_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      prod_a_ff    <= prod_a_in;
      den_a_ff     <= den_a_in;
      q_ff         <= q_in;
      res_h_ff     <= res_h_in;
      res_n_ff     <= res_n_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ------------------------------------------------------------ assertions
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |->
         (col_ff >= xs_ff) && (col_ff <= xe_ff) && (row_ff >= ys_ff) && (row_ff <= ye_ff))
      else $error("map read outside clipped window");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= WIN_CELLS)
      else $error("valid cell count exceeds window size");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[22:16] == 7'd0)) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("nonzero height with no valid cells");

endmodule
`default_nettype wire

/* verif/tb_elevation_window_average_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevation_window_average_top: self-checking bench for the window average
// A directed table covers the empty map, clipping, missing data and saturation.
// Random phases follow: new register settings, map writes and position queries.
// Window cells are written before a query reads them. Each response is checked
// field by field against an in-bench height predictor or a typed-in answer.
// ----------------------------------------------------------------------------
module tb_elevation_window_average_top
   import ewa_pkg::*;
();

   localparam int MAP_COLS      = MAP_COLS_MAX_DEF;
   localparam int MAP_ROWS      = MAP_ROWS_MAX_DEF;
   localparam int MAP_CELLS     = MAP_COLS * MAP_ROWS;
   localparam int RADIUS        = WINDOW_RADIUS_DEF;
   // worst query: three divisions, a full-window scan, overhead, one stall
   localparam int SETTLE_CYCLES = 3 * 31 + 121 + 13 + 20;
   localparam int CYCLE_LIMIT   = 5_000_000;
   // every request transaction counts, window fill writes included
   localparam int TOTAL_ITEMS   = 650;
   localparam int PHASE_ITEMS   = 63;
   localparam int DIRECTED_ROWS = 30;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_WRITE,
      ROW_QUERY
   } row_kind_type;

   typedef struct packed {
      logic signed [15:0] height;
      logic [6:0]         cells;
   } height_result_type;

   typedef struct packed {
      row_kind_type       kind;
      ewa_reg_type        reg_idx;
      logic [15:0]        reg_value;
      logic [7:0]         col;
      logic [7:0]         row;
      logic [7:0]         value;
      logic signed [16:0] px;
      logic signed [16:0] py;
      bit                 typed;
      logic signed [15:0] exp_height;
      logic [6:0]         exp_cells;
   } directed_step_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   ewa_cfg_type       cfg_shadow;
   logic [7:0]        height_map_model [0:MAP_CELLS-1];
   bit                cell_written [0:MAP_CELLS-1];
   height_result_type pending_heights [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                items_sent = 0;
   bit                req_idle_on = 1'b1;
   bit                rsp_idle_on = 1'b1;

   // single-cell map at (0,0) keeps the typed-in answers easy to read off
   directed_step_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'h0000, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b1, 16'sd0, 7'd0},
      '{ROW_CSR, REG_MAP_WIDTH, 16'd1, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0, 1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_MAP_HEIGHT, 16'd1, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0, 1'b0, 16'sd0, 7'd0},
      '{ROW_WRITE, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd254, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, -17'sd15000,
        1'b1, 16'sd1000, 7'd1},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd65535, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      // both coordinates at -65536
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'h10000, 17'h10000,
        1'b0, 16'sd0, 7'd0},
      // zero field extents act as one millimetre
      '{ROW_CSR, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0, 1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_FIELD_HEIGHT, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0, 1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd6, -17'sd1,
        1'b1, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, -17'sd6, -17'sd1,
        1'b1, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd5, -17'sd1,
        1'b0, 16'sd0, 7'd0},
      '{ROW_WRITE, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd255, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, -17'sd1,
        1'b1, 16'sd0, 7'd0},
      '{ROW_CSR, REG_MISSING, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0, 1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, -17'sd1,
        1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_HEIGHT_LOW, 16'h8000, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_HEIGHT_HIGH, 16'h7FFF, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, -17'sd1,
        1'b1, 16'sd32767, 7'd1},
      '{ROW_CSR, REG_HEIGHT_LOW, 16'h7FFF, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_HEIGHT_HIGH, 16'h8000, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, -17'sd1,
        1'b1, 16'h8000, 7'd1},
      // zero byte now equals the no-data code
      '{ROW_WRITE, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd0, -17'sd1,
        1'b1, 16'sd0, 7'd0},
      '{ROW_WRITE, REG_FIELD_WIDTH, 16'd0, 8'd255, 8'd255, 8'd128, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_WRITE, REG_FIELD_WIDTH, 16'd0, 8'd170, 8'd85, 8'd85, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_FIELD_WIDTH, 16'hFFFF, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_CSR, REG_FIELD_HEIGHT, 16'hFFFF, 8'd0, 8'd0, 8'd0, 17'sd0, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'sd65535, 17'sd0,
        1'b0, 16'sd0, 7'd0},
      '{ROW_QUERY, REG_FIELD_WIDTH, 16'd0, 8'd0, 8'd0, 8'd0, 17'h10000, 17'sd65535,
        1'b0, 16'sd0, 7'd0}
   };

   elevation_window_average_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // col[7:0] row[15:8] value[23:16] x[40:24] y[57:41]
      .req_tuser  (req_tuser),   // operation[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // height_mm[15:0] valid_cells[22:16]
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // clipped window around the cell that a field position maps to
   function automatic bit window_of(input logic signed [16:0] px, input logic signed [16:0] py,
                                    output int xs, output int xe, output int ys, output int ye);
      longint cols, rows, fw, fh, cx, cy;
      cols = (cfg_shadow.map_width_used > MAP_COLS) ? MAP_COLS : cfg_shadow.map_width_used;
      rows = (cfg_shadow.map_height_used > MAP_ROWS) ? MAP_ROWS : cfg_shadow.map_height_used;
      fw   = (cfg_shadow.field_width_mm == 0) ? 1 : cfg_shadow.field_width_mm;
      fh   = (cfg_shadow.field_height_mm == 0) ? 1 : cfg_shadow.field_height_mm;
      xs = 0; xe = -1; ys = 0; ye = -1;
      if (cols == 0 || rows == 0)
         return 1'b0;
      // signed division truncates toward zero
      cx = (cols * longint'(px)) / fw;
      cy = (rows * (longint'(py) + fh)) / fh;
      xs = (cx - RADIUS < 0) ? 0 : int'(cx - RADIUS);
      xe = (cx + RADIUS > cols - 1) ? int'(cols - 1) : int'(cx + RADIUS);
      ys = (cy - RADIUS < 0) ? 0 : int'(cy - RADIUS);
      ye = (cy + RADIUS > rows - 1) ? int'(rows - 1) : int'(cy + RADIUS);
      return 1'b1;
   endfunction

   function automatic height_result_type expected_window_height(input logic signed [16:0] px,
                                                                input logic signed [16:0] py);
      int xs, xe, ys, ye;
      longint sum, cnt, h;
      logic [7:0] map_byte;
      height_result_type res;
      res = '0;
      sum = 0;
      cnt = 0;
      if (!window_of(px, py, xs, xe, ys, ye))
         return res;
      for (int r = ys; r <= ye; r++) begin
         for (int c = xs; c <= xe; c++) begin
            map_byte = height_map_model[r * MAP_COLS + c];
            if (map_byte != cfg_shadow.missing_code) begin
               sum += map_byte;
               cnt++;
            end
         end
      end
      if (cnt == 0)
         return res;
      h = longint'($signed(cfg_shadow.height_low_mm)) +
          sum * (longint'($signed(cfg_shadow.height_high_mm)) -
                 longint'($signed(cfg_shadow.height_low_mm))) / (FULL_SCALE * cnt);
      if (h > 32767)
         h = 32767;
      if (h < -32768)
         h = -32768;
      res.height = h[15:0];
      res.cells  = (cnt > 127) ? 7'd127 : cnt[6:0];
      return res;
   endfunction

   function automatic logic [7:0] random_cell_value();
      return ($urandom_range(0, 6) == 0) ? cfg_shadow.missing_code : 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_field_extent();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom);
         default: return 16'($urandom_range(16, 2000));
      endcase
   endfunction

   function automatic logic [8:0] pick_map_extent();
      case ($urandom_range(0, 9))
         0: return 9'd0;
         1: return 9'd256;
         2: return 9'($urandom_range(257, 511));
         3: return 9'($urandom_range(49, 255));
         default: return 9'($urandom_range(1, 48));
      endcase
   endfunction

   task automatic csr_write(input ewa_reg_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_FIELD_WIDTH:  cfg_shadow.field_width_mm  = val;
         REG_FIELD_HEIGHT: cfg_shadow.field_height_mm = val;
         REG_HEIGHT_LOW:   cfg_shadow.height_low_mm   = val;
         REG_HEIGHT_HIGH:  cfg_shadow.height_high_mm  = val;
         REG_MISSING:      cfg_shadow.missing_code    = val[7:0];
         REG_MAP_WIDTH:    cfg_shadow.map_width_used  = val[8:0];
         REG_MAP_HEIGHT:   cfg_shadow.map_height_used = val[8:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one transaction on the request side; the model is updated at acceptance
   task automatic push_item(input ewa_op_type op, input logic [7:0] col,
                            input logic [7:0] row, input logic [7:0] value,
                            input logic signed [16:0] px, input logic signed [16:0] py,
                            input bit typed, input height_result_type typed_res);
      int gap;
      height_result_type exp_res;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, py, px, value, row, col};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_WRITE) begin
         height_map_model[int'(row) * MAP_COLS + col] = value;
         cell_written[int'(row) * MAP_COLS + col]     = 1'b1;
      end else begin
         exp_res         = typed ? typed_res : expected_window_height(px, py);
         pending_heights = {pending_heights, exp_res};
      end
   endtask

   // never let a query read a cell that holds no written byte
   task automatic send_query(input logic signed [16:0] px, input logic signed [16:0] py,
                             input bit typed, input height_result_type typed_res);
      int xs, xe, ys, ye;
      if (window_of(px, py, xs, xe, ys, ye)) begin
         for (int r = ys; r <= ye; r++) begin
            for (int c = xs; c <= xe; c++) begin
               if (!cell_written[r * MAP_COLS + c])
                  push_item(OP_WRITE, 8'(c), 8'(r), random_cell_value(),
                            17'($urandom), 17'($urandom), 1'b0, '0);
            end
         end
      end
      push_item(OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), px, py, typed, typed_res);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      // trailing writes may still occupy the block
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random stalls, compare against the oldest expectation
   initial begin
      int stall;
      height_result_type want;
      logic signed [15:0] got_height;
      logic [6:0] got_cells;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got_height = rsp_tdata[15:0];
         got_cells  = rsp_tdata[22:16];
         if (pending_heights.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual height_mm %0d valid_cells %0d",
                     $time, got_height, got_cells);
            mismatch_count++;
         end else begin
            want = pending_heights.pop_front();
            if (got_height !== want.height) begin
               $display("%0t: height_mm expected %0d, actual %0d",
                        $time, want.height, got_height);
               mismatch_count++;
            end
            if (got_cells !== want.cells) begin
               $display("%0t: valid_cells expected %0d, actual %0d",
                        $time, want.cells, got_cells);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL elevation_window_average_top");
      $finish;
   end

   initial begin
      directed_step_type step;
      bit prev_csr;
      int lo, hi, cols_eff, rows_eff, fw_eff, fh_eff;
      int phase_idx, next_phase;
      logic [7:0] missing_val;
      logic [8:0] map_w, map_h;
      logic [7:0] wc, wr;
      logic signed [16:0] qx, qy;

      cfg_shadow = '{FIELD_WIDTH_RST, FIELD_HEIGHT_RST, HEIGHT_LOW_RST, HEIGHT_HIGH_RST,
                     MISSING_RST, MAP_USED_RST, MAP_USED_RST};
      prev_csr = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         step = directed_rows[i];
         case (step.kind)
            ROW_CSR: begin
               if (!prev_csr)
                  wait_drained();
               csr_write(step.reg_idx, step.reg_value);
            end
            ROW_WRITE: begin
               push_item(OP_WRITE, step.col, step.row, step.value, step.px, step.py,
                         1'b0, '0);
            end
            default: begin
               send_query(step.px, step.py, step.typed, {step.exp_height, step.exp_cells});
            end
         endcase
         prev_csr = (step.kind == ROW_CSR);
      end

      phase_idx  = 0;
      next_phase = items_sent;
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= next_phase) begin
            next_phase = items_sent + PHASE_ITEMS;
            wait_drained();
            csr_write(REG_FIELD_WIDTH, pick_field_extent());
            csr_write(REG_FIELD_HEIGHT, pick_field_extent());
            case ($urandom_range(0, 3))
               0: begin lo = -32768; hi = 32767; end
               1: begin lo = 32767; hi = -32768; end
               2: begin
                  lo = int'($urandom_range(0, 65535)) - 32768;
                  hi = int'($urandom_range(0, 65535)) - 32768;
               end
               default: begin
                  lo = int'($urandom_range(0, 2000)) - 1000;
                  hi = lo + int'($urandom_range(0, 3000));
               end
            endcase
            csr_write(REG_HEIGHT_LOW, 16'(lo));
            csr_write(REG_HEIGHT_HIGH, 16'(hi));
            case ($urandom_range(0, 2))
               0: missing_val = 8'hFF;
               1: missing_val = 8'h00;
               default: missing_val = 8'($urandom);
            endcase
            csr_write(REG_MISSING, 16'(missing_val));
            // first phases force the largest and the empty map
            if (phase_idx == 0) begin
               map_w = 9'h1FF;
               map_h = 9'h1FF;
            end else if (phase_idx == 1) begin
               map_w = 9'd0;
               map_h = pick_map_extent();
            end else begin
               map_w = pick_map_extent();
               map_h = pick_map_extent();
            end
            csr_write(REG_MAP_WIDTH, 16'(map_w));
            csr_write(REG_MAP_HEIGHT, 16'(map_h));
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            phase_idx++;
         end

         if ($urandom_range(0, 9) < 3) begin
            cols_eff = (map_w == 0 || map_w > MAP_COLS) ? MAP_COLS : map_w;
            rows_eff = (map_h == 0 || map_h > MAP_ROWS) ? MAP_ROWS : map_h;
            if ($urandom_range(0, 3) != 0) begin
               wc = 8'($urandom_range(0, cols_eff - 1));
               wr = 8'($urandom_range(0, rows_eff - 1));
            end else begin
               wc = 8'($urandom);
               wr = 8'($urandom);
            end
            push_item(OP_WRITE, wc, wr, random_cell_value(), 17'($urandom), 17'($urandom),
                      1'b0, '0);
         end else begin
            // mostly positions inside the field, the rest anywhere
            if ($urandom_range(0, 3) != 0) begin
               fw_eff = (cfg_shadow.field_width_mm == 0) ? 1 : cfg_shadow.field_width_mm;
               fh_eff = (cfg_shadow.field_height_mm == 0) ? 1 : cfg_shadow.field_height_mm;
               qx = 17'($urandom_range(0, fw_eff));
               qy = 17'(-int'($urandom_range(0, fh_eff)));
            end else begin
               qx = 17'($urandom);
               qy = 17'($urandom);
            end
            send_query(qx, qy, 1'b0, '0);
         end
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("PASS elevation_window_average_top");
      else
         $display("FAIL elevation_window_average_top");
      $finish;
   end

endmodule

/* elevation_window_average_top.f */
design/ewa_pkg.sv
design/ewa_ram.sv
design/ewa_div.sv
design/ewa_csr.sv
design/elevation_window_average_top.sv
verif/tb_elevation_window_average_top.sv
